>>> hw/rtl/gf2_poly_gcd_code_dimension_top_assert.svh
// Assertion macros for the checker file of this block.
`ifndef GF2_POLY_GCD_CODE_DIMENSION_TOP_ASSERT_SVH
`define GF2_POLY_GCD_CODE_DIMENSION_TOP_ASSERT_SVH

// Checks a property on every clock edge outside reset.
`define GPGCD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a signal keeps its value into the cycle after a trigger.
`define GPGCD_ASSERT_HOLD(label, clk, rst, trig, sig, msg) \
   label: assert property (@(posedge clk) disable iff (rst) trig |=> $stable(sig)) \
      else $error(msg);

`endif

>>> hw/rtl/gpgcd_pkg.sv
package gpgcd_pkg;

   // Default polynomial width in coefficients.
   localparam int POLY_WIDTH = 128;

   // Input field widths and their places in the request beat.
   localparam int LOW_W       = 64;
   localparam int HIGH_W      = 63;
   localparam int FULL_W      = LOW_W + HIGH_W + 1;
   localparam int A_LOW_LSB   = 0;
   localparam int A_HIGH_LSB  = A_LOW_LSB + LOW_W;
   localparam int B_LOW_LSB   = A_HIGH_LSB + HIGH_W;
   localparam int B_HIGH_LSB  = B_LOW_LSB + LOW_W;
   localparam int REQ_DATA_W  = 256;

   // Result and configuration widths.
   localparam int COUNT_W     = 8;
   localparam int CFG_W       = 7;
   localparam logic [CFG_W-1:0] CYCLE_LENGTH_RESET = 7'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic step;
      logic chain;
      logic capture;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic done;
   } status_type;

endpackage

>>> hw/rtl/gpgcd_datapath.sv
module gpgcd_datapath #(
   parameter int POLY_WIDTH = gpgcd_pkg::POLY_WIDTH
) (
   input  logic                           clock,
   input  gpgcd_pkg::cmd_type             cmd,
   input  logic [POLY_WIDTH-1:0]          poly_a,
   input  logic [POLY_WIDTH-1:0]          poly_b,
   input  logic [gpgcd_pkg::CFG_W-1:0]    cycle_length,
   output gpgcd_pkg::status_type          status,
   output logic [gpgcd_pkg::COUNT_W-1:0]  result
);

   localparam int DW = $clog2(POLY_WIDTH);
   localparam logic [DW-1:0] TOP_DEG = DW'(POLY_WIDTH - 1);
   localparam logic [POLY_WIDTH-1:0] MSB_ONE = {1'b1, {(POLY_WIDTH-1){1'b0}}};

   // Two operands kept left-aligned: bit POLY_WIDTH-1 holds the coefficient of
   // the degree in the matching counter. A zero flag marks an operand that is gone.
   logic [POLY_WIDTH-1:0] u_ff, u_in, v_ff, v_in, b_ff, b_in;
   logic [DW-1:0]         du_ff, du_in, dv_ff, dv_in;
   logic                  uz_ff, uz_in, vz_ff, vz_in;
   logic [gpgcd_pkg::COUNT_W-1:0] result_ff, result_in;

   logic [DW-1:0]         len_eff;
   logic [POLY_WIDTH-1:0] modulus;
   logic                  u_norm, v_norm;

   // Cycle length saturated to the width, and x^L+1 in aligned form.
   always_comb begin
      if ({1'b0, cycle_length} > 8'(POLY_WIDTH - 1)) begin
         len_eff = TOP_DEG;
      end else begin
         len_eff = DW'(cycle_length);
      end
      modulus = MSB_ONE | (MSB_ONE >> len_eff);
   end

   assign u_norm = uz_ff || u_ff[POLY_WIDTH-1];
   assign v_norm = vz_ff || v_ff[POLY_WIDTH-1];
   assign status.done = u_norm && v_norm && (uz_ff || vz_ff);

   // One Euclid step per cycle while step is commanded: each unaligned operand is
   // shifted up toward its leading term, or the lower-degree one is cancelled from the other.
   always_comb begin
      u_in      = u_ff;
      v_in      = v_ff;
      b_in      = b_ff;
      du_in     = du_ff;
      dv_in     = dv_ff;
      uz_in     = uz_ff;
      vz_in     = vz_ff;
      result_in = result_ff;

      if (cmd.load) begin
         u_in  = modulus;
         du_in = len_eff;
         uz_in = 1'b0;
         v_in  = poly_a;
         dv_in = TOP_DEG;
         vz_in = 1'b0;
         b_in  = poly_b;
      end

      if (cmd.step) begin
         if (!u_norm) begin
            if (du_ff == '0) begin
               uz_in = 1'b1;
            end else begin
               u_in  = u_ff << 1;
               du_in = du_ff - 1'b1;
            end
         end
         if (!v_norm) begin
            if (dv_ff == '0) begin
               vz_in = 1'b1;
            end else begin
               v_in  = v_ff << 1;
               dv_in = dv_ff - 1'b1;
            end
         end
         if (u_norm && v_norm && !uz_ff && !vz_ff) begin
            if (du_ff >= dv_ff) begin
               if (du_ff == '0) begin
                  uz_in = 1'b1;
               end else begin
                  u_in  = (u_ff ^ v_ff) << 1;
                  du_in = du_ff - 1'b1;
               end
            end else begin
               v_in  = (v_ff ^ u_ff) << 1;
               dv_in = dv_ff - 1'b1;
            end
         end
      end

      // The surviving operand stays; b replaces the one that went to zero.
      if (cmd.chain) begin
         if (uz_ff) begin
            u_in  = b_ff;
            du_in = TOP_DEG;
            uz_in = 1'b0;
         end else begin
            v_in  = b_ff;
            dv_in = TOP_DEG;
            vz_in = 1'b0;
         end
      end

      // The count is twice the degree of the surviving operand.
      if (cmd.capture) begin
         if (uz_ff) begin
            result_in = gpgcd_pkg::COUNT_W'({dv_ff, 1'b0});
         end else begin
            result_in = gpgcd_pkg::COUNT_W'({du_ff, 1'b0});
         end
      end
   end

   always_ff @(posedge clock) begin
      u_ff      <= u_in;
      v_ff      <= v_in;
      b_ff      <= b_in;
      du_ff     <= du_in;
      dv_ff     <= dv_in;
      uz_ff     <= uz_in;
      vz_ff     <= vz_in;
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

>>> hw/rtl/gpgcd_ctrl.sv
module gpgcd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  gpgcd_pkg::status_type status,
   output gpgcd_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN_A,
      ST_RUN_B,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;

   // Sequencing: gcd of the modulus with a, then of that with b, then the result.
   always_comb begin
      cmd           = '0;
      state_in      = state_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN_A;
            end
         end
         ST_RUN_A: begin
            if (status.done) begin
               cmd.chain = 1'b1;
               state_in  = ST_RUN_B;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_RUN_B: begin
            if (status.done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               cmd.capture   = 1'b1;
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

>>> hw/rtl/gf2_poly_gcd_code_dimension_top.sv
// Computes K = 2*deg(gcd(a, b, x^L+1)) over GF(2) for two binary polynomials a and b
// taken from one request beat, with L from the cycle length register (reset 3,
// saturated to POLY_WIDTH-1; L of zero gives K of zero; a and b both zero give
// K = 2L). One beat is worked at a time: the shift-and-xor Euclid datapath lowers
// an operand degree by at least one per cycle in each of the two gcd passes. Before,
// between and after them come a load, a hand-over of the surviving operand to the
// second pass and the posting of the result; the next beat is taken only after that,
// and posting waits while an earlier result is still stalled at the output. The
// result sits in an output register, so a new beat is accepted while an earlier
// result still waits to be taken.
module gf2_poly_gcd_code_dimension_top #(
   parameter int POLY_WIDTH = gpgcd_pkg::POLY_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   // Fields from bit 0 up: poly_a_low (64), poly_a_high (63), poly_b_low (64),
   // poly_b_high (63), two zero bits.
   input  logic [gpgcd_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // Fields from bit 0 up: logical_count (8).
   output logic [gpgcd_pkg::COUNT_W-1:0]     rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_wr_en,
   input  logic [gpgcd_pkg::CFG_W-1:0]       csr_wr_data
);

   logic [gpgcd_pkg::CFG_W-1:0]  cycle_length_ff;
   logic [gpgcd_pkg::FULL_W-1:0] a_full, b_full;
   gpgcd_pkg::cmd_type           cmd;
   gpgcd_pkg::status_type        status;

   // Cycle length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_length_ff <= gpgcd_pkg::CYCLE_LENGTH_RESET;
      end else if (csr_wr_en) begin
         cycle_length_ff <= csr_wr_data;
      end
   end

   // Unpack both polynomials; coefficients at or above POLY_WIDTH are dropped.
   assign a_full = {1'b0,
      req_tdata[gpgcd_pkg::A_HIGH_LSB +: gpgcd_pkg::HIGH_W],
      req_tdata[gpgcd_pkg::A_LOW_LSB +: gpgcd_pkg::LOW_W]};
   assign b_full = {1'b0,
      req_tdata[gpgcd_pkg::B_HIGH_LSB +: gpgcd_pkg::HIGH_W],
      req_tdata[gpgcd_pkg::B_LOW_LSB +: gpgcd_pkg::LOW_W]};

   gpgcd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gpgcd_datapath #(
      .POLY_WIDTH (POLY_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .poly_a       (a_full[POLY_WIDTH-1:0]),
      .poly_b       (b_full[POLY_WIDTH-1:0]),
      .cycle_length (cycle_length_ff),
      .status       (status),
      .result       (rsp_tdata)
   );

endmodule

>>> hw/rtl/gpgcd_checker.sv
`include "gf2_poly_gcd_code_dimension_top_assert.svh"

module gpgcd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [gpgcd_pkg::COUNT_W-1:0]    rsp_tdata,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready
);

   logic rsp_stall;
   logic req_beat;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign req_beat  = req_tvalid && req_tready;

   // A stalled result keeps both its valid and its value.
   `GPGCD_ASSERT(a_rsp_valid_held, clock, reset, rsp_stall |=> rsp_tvalid, "result dropped")
   `GPGCD_ASSERT_HOLD(a_rsp_data_held, clock, reset, rsp_stall, rsp_tdata, "result changed")

   // The count is twice a degree, so it is always even.
   `GPGCD_ASSERT(a_count_even, clock, reset, rsp_tvalid |-> !rsp_tdata[0], "odd count")

   // Items are worked one at a time: no beat is taken right after another.
   `GPGCD_ASSERT(a_one_item, clock, reset, req_beat |=> !req_tready, "second beat taken")

endmodule

bind gf2_poly_gcd_code_dimension_top gpgcd_checker u_gpgcd_checker (.*);

>>> test/tb_top.sv
module tb_top;

   localparam int LOW_W      = gpgcd_pkg::LOW_W;
   localparam int HIGH_W     = gpgcd_pkg::HIGH_W;
   localparam int REQ_DATA_W = gpgcd_pkg::REQ_DATA_W;
   localparam int COUNT_W    = gpgcd_pkg::COUNT_W;
   localparam int CFG_W      = gpgcd_pkg::CFG_W;
   localparam logic [CFG_W-1:0] CYCLE_LENGTH_RESET = gpgcd_pkg::CYCLE_LENGTH_RESET;

   // Polynomials are handled at the full 128-bit width of the datapath.
   typedef logic [127:0] poly_type;

   // One request beat, last member in the lowest bits.
   typedef struct packed {
      logic [HIGH_W-1:0] b_high;
      logic [LOW_W-1:0]  b_low;
      logic [HIGH_W-1:0] a_high;
      logic [LOW_W-1:0]  a_low;
   } gcd_item_type;

   // Receiver pacing modes.
   typedef enum int {
      STALL_NONE,
      STALL_COIN,
      STALL_PERIODIC,
      STALL_HOLD
   } stall_mode_type;

   localparam int IDLE_LIMIT  = 5000;
   localparam int DRAIN_WAIT  = 600;
   localparam int PHASE_ITEMS = 150;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [COUNT_W-1:0]    rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic                  csr_wr_en   = 1'b0;
   logic [CFG_W-1:0]      csr_wr_data = '0;

   // Expected code dimensions in order of acceptance.
   logic [COUNT_W-1:0] dimension_queue[$];
   logic [CFG_W-1:0]   cycle_length_model = CYCLE_LENGTH_RESET;
   logic [127:0]       lengths_seen = '0;
   int                 fail_count   = 0;
   int                 items_sent   = 0;
   int                 results_seen = 0;
   int                 burst_left   = 0;
   bit                 gaps_enabled = 1'b1;

   gf2_poly_gcd_code_dimension_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Degree of a polynomial, or -1 for the zero polynomial.
   function automatic int poly_degree(poly_type p);
      for (int i = 127; i >= 0; i--) begin
         if (p[i]) return i;
      end
      return -1;
   endfunction

   // Remainder of a divided by b by repeated shift-and-xor.
   function automatic poly_type poly_mod(poly_type a, poly_type b);
      int da;
      int db;
      db = poly_degree(b);
      if (db < 0) return '0;
      da = poly_degree(a);
      while (da >= db) begin
         a ^= b << (da - db);
         da = poly_degree(a);
      end
      return a;
   endfunction

   function automatic poly_type poly_gcd(poly_type a, poly_type b);
      poly_type r;
      while (b != '0) begin
         r = poly_mod(a, b);
         a = b;
         b = r;
      end
      return a;
   endfunction

   // Carry-less product; callers keep the degree sum below 128.
   function automatic poly_type poly_mul(poly_type x, poly_type y);
      poly_type r;
      r = '0;
      for (int i = 0; i < 128; i++) begin
         if (y[i]) r ^= x << i;
      end
      return r;
   endfunction

   // K = 2 * deg(gcd(a, b, x^L+1)); L of zero gives the modulus 1.
   function automatic logic [COUNT_W-1:0] predict_dimension(poly_type a, poly_type b,
                                                          logic [CFG_W-1:0] len);
      poly_type modulus;
      int       deg;
      modulus = (poly_type'(1) << len) | poly_type'(1);
      deg = poly_degree(poly_gcd(poly_gcd(a, b), modulus));
      if (deg < 0) deg = 0;
      return COUNT_W'(2 * deg);
   endfunction

   function automatic poly_type random_poly(int max_deg);
      poly_type v;
      v = {$urandom, $urandom, $urandom, $urandom};
      return v & ((poly_type'(1) << (max_deg + 1)) - poly_type'(1));
   endfunction

   // Drives one beat after an optional burst gap and waits for its handshake.
   task automatic send_poly(input poly_type a, input poly_type b);
      gcd_item_type item;
      int           gap;
      item.a_low  = a[LOW_W-1:0];
      item.a_high = a[LOW_W+HIGH_W-1:LOW_W];
      item.b_low  = b[LOW_W-1:0];
      item.b_high = b[LOW_W+HIGH_W-1:LOW_W];
      if (burst_left == 0) begin
         gap = gaps_enabled ? $urandom_range(1, 12) : 0;
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tdata  <= {2'b00, item};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      dimension_queue.push_back(predict_dimension({1'b0, item.a_high, item.a_low},
                                                  {1'b0, item.b_high, item.b_low},
                                                  cycle_length_model));
      items_sent++;
   endtask

   // Lowers valid and waits until every expected result has been taken.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (dimension_queue.size() != 0) @(posedge clock);
   endtask

   task automatic set_cycle_length(input logic [CFG_W-1:0] len);
      wait_idle();
      csr_wr_data <= len;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cycle_length_model = len;
      lengths_seen[len] = 1'b1;
   endtask

   // Random beat: pairs sharing a divisor of x^L+1, random pairs, zero or sparse operands.
   task automatic send_random(input logic [CFG_W-1:0] len);
      poly_type a;
      poly_type b;
      poly_type g;
      int       d;
      int       kind;
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
         a = random_poly(126);
         b = random_poly(126);
      end else if (kind <= 7) begin
         // x^d+1 divides x^L+1 whenever d divides L; d stays within 126 so
         // that the divisor fits in the 127 coefficients of a beat.
         if (len == 0) begin
            d = 0;
            g = poly_type'(1);
         end else begin
            d = $urandom_range(1, (len > 126) ? 126 : len);
            while (len % d != 0) d--;
            g = (poly_type'(1) << d) | poly_type'(1);
         end
         a = poly_mul(g, random_poly($urandom_range(0, 126 - d)));
         b = poly_mul(g, random_poly($urandom_range(0, 126 - d)));
         if (kind == 7) b = g;
      end else if (kind == 8) begin
         // One or both operands zero.
         a = ($urandom_range(0, 2) == 0) ? '0 : random_poly($urandom_range(0, 126));
         b = '0;
         if ($urandom_range(0, 1) == 1) begin
            b = a;
            a = '0;
         end
      end else begin
         // Sparse operands with a few coefficients set.
         a = '0;
         b = '0;
         repeat ($urandom_range(1, 3)) a[$urandom_range(0, 126)] = 1'b1;
         repeat ($urandom_range(1, 3)) b[$urandom_range(0, 126)] = 1'b1;
      end
      send_poly(a, b);
   endtask

   // Reset value of the cycle length, used without any register write.
   task automatic test_reset_length();
      lengths_seen[CYCLE_LENGTH_RESET] = 1'b1;
      send_poly('0, '0);
      send_poly(poly_type'(9), '0);
      send_poly(poly_type'(3), poly_type'(5));
      send_poly({1'b0, {127{1'b1}}}, {1'b0, {127{1'b1}}});
      send_poly(poly_type'(1), '0);
   endtask

   // Largest, smallest and zero cycle lengths, plus a length of 64, with the field extremes.
   task automatic test_extreme_lengths();
      set_cycle_length(7'd127);
      send_poly('0, '0);
      send_poly({1'b0, {127{1'b1}}}, '0);
      send_poly(poly_type'(1) << 126, '0);
      send_poly('0, {1'b0, {127{1'b1}}});
      send_poly({64'd0, {64{1'b1}}}, {1'b0, {63{1'b1}}, 64'd0});

      set_cycle_length(7'd1);
      send_poly('0, '0);
      send_poly(poly_type'(3), '0);
      send_poly(poly_type'(2), '0);

      // A zero cycle length makes the modulus the constant one.
      set_cycle_length(7'd0);
      send_poly('0, '0);
      send_poly(poly_type'(3), poly_type'(3));
      send_poly({1'b0, {127{1'b1}}}, {1'b0, {127{1'b1}}});

      set_cycle_length(7'd64);
      send_poly('0, '0);
      send_poly((poly_type'(1) << 64) | poly_type'(1), '0);
      send_poly((poly_type'(1) << 63) | poly_type'(1), '0);
   endtask

   // Random phases, each under its own cycle length and sender pacing.
   task automatic test_random_lengths();
      int               fixed_lengths[10] = '{3, 127, 1, 0, 64, 63, 7, 15, 126, 2};
      logic [CFG_W-1:0] len;
      for (int phase = 0; phase < 12; phase++) begin
         len = (phase < 10) ? CFG_W'(fixed_lengths[phase]) : CFG_W'($urandom_range(0, 127));
         set_cycle_length(len);
         gaps_enabled = (phase % 3 != 2);
         repeat (PHASE_ITEMS) send_random(len);
      end
   endtask

   // Result checker: each beat against the oldest expected dimension.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (dimension_queue.size() == 0) begin
            $error("logical_count: expected none, actual %0d", rsp_tdata);
            fail_count++;
         end else begin
            if (rsp_tdata !== dimension_queue[0]) begin
               $error("logical_count: expected %0d, actual %0d",
                      dimension_queue[0], rsp_tdata);
               fail_count++;
            end
            void'(dimension_queue.pop_front());
         end
      end
   end

   // Receiver backpressure: modes of free flow, coin flips, a periodic
   // pattern and long stalls, with the mode picked anew at random.
   stall_mode_type stall_mode  = STALL_NONE;
   int             mode_cycles = 0;
   int             hold_cycles = 0;
   int             tick        = 0;
   bit             hold_level  = 1'b1;

   always @(posedge clock) begin
      tick++;
      if (mode_cycles == 0) begin
         stall_mode  = stall_mode_type'($urandom_range(0, 3));
         mode_cycles = $urandom_range(100, 600);
      end else begin
         mode_cycles--;
      end
      case (stall_mode)
         STALL_NONE: begin
            rsp_tready <= 1'b1;
         end
         STALL_COIN: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         STALL_PERIODIC: begin
            rsp_tready <= (tick % 5 == 0);
         end
         default: begin
            if (hold_cycles == 0) begin
               hold_cycles = $urandom_range(1, 40);
               hold_level  = ~hold_level;
            end
            hold_cycles--;
            rsp_tready <= hold_level;
         end
      endcase
   end

   // Watchdog on cycles without any beat or register write.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en || reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout after %0d idle cycles with %0d results outstanding.",
                  idle_cycles, dimension_queue.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_length();
      test_extreme_lengths();
      test_random_lengths();

      // Drain, then keep watching for stray results.
      wait_idle();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (dimension_queue.size() != 0) begin
         $error("logical_count: %0d expected results never arrived",
                dimension_queue.size());
         fail_count++;
      end

      $display("Sent %0d beats and checked %0d results over %0d cycle lengths.",
               items_sent, results_seen, $countones(lengths_seen));
      $display("Covered zero operands, zero and maximal lengths, and shared divisors.");
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

>>> gf2_poly_gcd_code_dimension_top.f
+incdir+hw/rtl
hw/rtl/gpgcd_pkg.sv
hw/rtl/gpgcd_datapath.sv
hw/rtl/gpgcd_ctrl.sv
hw/rtl/gf2_poly_gcd_code_dimension_top.sv
hw/rtl/gpgcd_checker.sv
test/tb_top.sv
